// File: design/htwd_pkg.sv
// shared types and constants of the huffman tree walk decoder
`timescale 1ns / 1ps

package htwd_pkg;

	localparam int IDX_W      = 9;
	localparam int SYM_W      = 8;
	localparam int BYTE_BITS  = 8;
	localparam int CNT_W      = 4;
	localparam int NODE_COUNT_DEFAULT = 512;
	// child indexes are nine bits wide, so no more entries can ever be reached
	localparam int IDX_SPAN   = 1 << IDX_W;

	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_DECODE  = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MISSING = 2'd1,
		ST_STICKY  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_STEP,
		S_LOOK,
		S_FINISH
	} fsm_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [IDX_W-1:0]  node_index;
		logic [IDX_W-1:0]  left_child;
		logic [IDX_W-1:0]  right_child;
		logic [SYM_W-1:0]  leaf_symbol;
		logic [SYM_W-1:0]  data_byte;
		logic [CNT_W-1:0]  valid_bits;
	} in_item_t;

	typedef struct packed {
		logic              has_symbol;
		logic [SYM_W-1:0]  symbol;
		status_t           status;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  left;
		logic [IDX_W-1:0]  right;
		logic [SYM_W-1:0]  sym;
	} node_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic restart;
		logic begin_dec;
		logic sticky;
		logic fetch_done;
		logic advance;
		logic miss;
		logic land;
		logic finish;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic err;
		logic bits_done;
		logic miss;
	} dp_sts_t;

endpackage

// File: design/htwd_ctrl.sv
// controller state machine of the huffman tree walk decoder
`timescale 1ns / 1ps

module htwd_ctrl import htwd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	input  dp_sts_t sts,
	output dp_cmd_t ctl,
	output logic    busy
);

	fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start && cmd == CMD_DECODE) begin
					state_d = sts.err ? S_FINISH : S_FETCH;
				end
			end
			S_FETCH: state_d = S_STEP;
			S_STEP: begin
				if (sts.bits_done || sts.miss) begin
					state_d = S_FINISH;
				end else begin
					state_d = S_LOOK;
				end
			end
			S_LOOK:   state_d = S_STEP;
			S_FINISH: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl  = '0;
		busy = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					case (cmd)
						CMD_LOAD:    ctl.load = 1'b1;
						CMD_RESTART: ctl.restart = 1'b1;
						CMD_DECODE: begin
							ctl.sticky    = sts.err;
							ctl.begin_dec = !sts.err;
						end
						default: ;
					endcase
				end
			end
			S_FETCH: ctl.fetch_done = 1'b1;
			S_STEP: begin
				if (!sts.bits_done) begin
					ctl.miss    = sts.miss;
					ctl.advance = !sts.miss;
				end
			end
			S_LOOK:   ctl.land = 1'b1;
			S_FINISH: ctl.finish = 1'b1;
			default: ;
		endcase
	end

endmodule

// File: design/htwd_dp.sv
// datapath of the huffman tree walk decoder: node table, walk registers, result staging
`timescale 1ns / 1ps

module htwd_dp import htwd_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  req,
	input  dp_cmd_t   ctl,
	output dp_sts_t   sts,
	output out_item_t rsp,
	output logic      rsp_strobe
);

	localparam int TABLE_DEPTH = (NODE_COUNT < IDX_SPAN) ? NODE_COUNT : IDX_SPAN;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);

	node_t table_q [TABLE_DEPTH];
	node_t rd_q;
	node_t ent_q;
	node_t root_q;

	logic [ADDR_W-1:0]    cur_q;
	logic [ADDR_W-1:0]    nxt_q;
	logic [BYTE_BITS-1:0] shift_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 err_q;
	out_item_t            pend_q;
	logic                 pend_v_q;
	out_item_t            res_q;
	logic                 res_v_q;

	logic [IDX_W-1:0]  next_idx;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic              is_leaf;
	logic              push;
	out_item_t         push_item;
	out_item_t         fin_item;
	logic [CNT_W-1:0]  cnt_init;

	assign next_idx = shift_q[BYTE_BITS-1] ? ent_q.right : ent_q.left;
	assign rd_addr  = ctl.begin_dec ? cur_q : next_idx[ADDR_W-1:0];
	assign wr_en    = ctl.load && (32'(req.node_index) < NODE_COUNT);
	assign is_leaf  = (rd_q.left == '0) && (rd_q.right == '0);
	assign cnt_init = (req.valid_bits > CNT_W'(BYTE_BITS)) ? CNT_W'(BYTE_BITS)
	                                                       : req.valid_bits;

	assign sts.err       = err_q;
	assign sts.bits_done = (cnt_q == '0);
	assign sts.miss      = (next_idx == '0) || (32'(next_idx) >= NODE_COUNT);

	// new result from a step: a missing child or a landed leaf
	always_comb begin
		push      = ctl.miss || (ctl.land && is_leaf);
		push_item = '0;
		if (ctl.miss) begin
			push_item.status = ST_MISSING;
		end else begin
			push_item.has_symbol = 1'b1;
			push_item.symbol     = rd_q.sym;
			push_item.status     = ST_OK;
		end
	end

	// final result of a decode: the staged one, or an empty report
	always_comb begin
		fin_item      = pend_v_q ? pend_q : '0;
		fin_item.last = 1'b1;
	end

	// node table, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_q[req.node_index[ADDR_W-1:0]] <= '{req.left_child, req.right_child,
				req.leaf_symbol};
		end
		rd_q <= table_q[rd_addr];
	end

	// walk payload
	always_ff @(posedge clk) begin
		if (wr_en && req.node_index == '0) begin
			root_q <= '{req.left_child, req.right_child, req.leaf_symbol};
		end
		if (ctl.begin_dec) begin
			shift_q <= req.data_byte;
		end else if (ctl.advance) begin
			shift_q <= shift_q << 1;
		end
		if (ctl.advance) begin
			nxt_q <= next_idx[ADDR_W-1:0];
		end
		if (ctl.fetch_done) begin
			ent_q <= rd_q;
		end else if (ctl.land) begin
			ent_q <= is_leaf ? root_q : rd_q;
		end
		if (ctl.sticky) begin
			pend_q <= '{1'b0, '0, ST_STICKY, 1'b0};
		end else if (push) begin
			pend_q <= push_item;
		end
		if (ctl.finish) begin
			res_q <= fin_item;
		end else if (push && pend_v_q) begin
			res_q <= pend_q;
		end
	end

	// walk control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= '0;
			cnt_q    <= '0;
			err_q    <= 1'b0;
			pend_v_q <= 1'b0;
			res_v_q  <= 1'b0;
		end else begin
			res_v_q <= ctl.finish || (push && pend_v_q);
			if (ctl.restart) begin
				cur_q <= '0;
				err_q <= 1'b0;
			end
			if (ctl.miss) begin
				err_q <= 1'b1;
			end
			if (ctl.land) begin
				cur_q <= is_leaf ? '0 : nxt_q;
			end
			if (ctl.begin_dec) begin
				cnt_q <= cnt_init;
			end else if (ctl.advance) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (ctl.begin_dec || ctl.finish) begin
				pend_v_q <= 1'b0;
			end else if (ctl.sticky || push) begin
				pend_v_q <= 1'b1;
			end
		end
	end

	assign rsp        = res_q;
	assign rsp_strobe = res_v_q;

endmodule

// File: design/huffman_tree_walk_decoder_core.sv
// top level of the huffman tree walk decoder
`timescale 1ns / 1ps

// channel    ports                  handshake
// ---------  ---------------------  ------------------------------------------------
// item in    req (in_item_t)        taken on a rising edge with start high, busy low
// result     rsp (out_item_t)       shown for one cycle while rsp_strobe is high
//
// load and restart items give no result
// a decode keeps busy high through FETCH, a STEP and LOOK per code bit walked, a last
// STEP and FINISH (only FINISH on a sticky error), bound by the table's one read port
// each result waits in a staging register until the next one is made or the walk ends,
// so the last flag is known when it leaves; the last one shows in the cycle busy drops
// the receiver cannot stall, so nothing is held back
// reset clears the walk position and the error flag; the node table has no clear and
// holds garbage until loaded

module huffman_tree_walk_decoder_core import htwd_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  req,
	output out_item_t rsp,
	output logic      rsp_strobe
);

	dp_cmd_t ctl;
	dp_sts_t sts;

	// sequencer: walks one code bit per STEP and LOOK pair
	htwd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (req.cmd),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	// table, walk registers and one-deep result staging for the last flag
	htwd_dp #(
		.NODE_COUNT (NODE_COUNT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.ctl        (ctl),
		.sts        (sts),
		.rsp        (rsp),
		.rsp_strobe (rsp_strobe)
	);

	// decode while in error answers with one sticky final result
	a_sticky_reply: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.cmd == CMD_DECODE && sts.err
		|=> ##1 (rsp_strobe && rsp.last && rsp.status == ST_STICKY))
		else $error("sticky error reply missing");

	// a missing child report leaves the error flag set
	a_miss_sets_err: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_strobe && rsp.status == ST_MISSING |-> sts.err && rsp.last)
		else $error("missing child reported without error flag");

	// a symbol result never carries an error status
	a_sym_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_strobe && rsp.has_symbol |-> rsp.status == ST_OK)
		else $error("symbol result with error status");

	// node loads produce no result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.cmd == CMD_LOAD |=> !rsp_strobe)
		else $error("result after node load");

endmodule
